/* hw/rtl/bsm_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the bell schedule matcher.
package bsm_pkg;

	localparam int WEEKLY_SLOTS = 16;
	localparam int PERIOD_SLOTS = 8;
	localparam int DAYS         = 7;

	localparam int WIDX = (WEEKLY_SLOTS > 1) ? $clog2(WEEKLY_SLOTS) : 1;
	localparam int WCW  = $clog2(WEEKLY_SLOTS + 1);
	localparam int PIDX = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
	localparam int PCW  = $clog2(PERIOD_SLOTS + 1);
	localparam int DIDX = $clog2(PERIOD_SLOTS * DAYS);

	localparam int HOUR_MIN   = 60;
	localparam int DAY_MIN    = 24 * 60;
	localparam int WEEK_MIN   = 24 * 60 * 7;
	localparam int DATE_SCALE = 100;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 5;

	typedef enum logic [1:0] {
		OP_LOAD_WEEKLY = 2'd0,
		OP_LOAD_DATES  = 2'd1,
		OP_LOAD_DAILY  = 2'd2,
		OP_EVAL        = 2'd3
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_WEEKLY_COUNT = 1'b0,
		CFG_PERIOD_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_P_ADDR,
		S_P_CHK,
		S_D_SCAN,
		S_W_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic            take;
		logic            cap;
		logic            p_rd;
		logic            d_rd;
		logic            w_rd;
		logic            load;
		logic [PIDX-1:0] pidx;
		logic [2:0]      off;
		logic [WIDX-1:0] widx;
	} cmd_t;

	typedef struct packed {
		logic           wd_ok;
		logic           in_per;
		logic [WCW-1:0] nw;
		logic [PCW-1:0] np;
	} stat_t;

endpackage

/* hw/rtl/bell_schedule_matcher.sv */
// Top level of the bell schedule matcher: controller and datapath.
//
// Load requests (weekly bell, period dates, period daily time) are taken while idle.
// An evaluate request captures the current date and time, then reads each period in use (none
// when the current weekday is out of range) and judges it in a separate step; for each period
// that contains the current date it scans that period's daily times for all seven days. It then
// scans the weekly bells in use and ends with a drain step and a finish step. Each table has a
// single read port: one daily time or one weekly bell is read and judged per cycle. A finished
// result is held in an output register, so loads and the next evaluate may be accepted while it
// waits to be taken. Tables are not cleared at reset; set the counts and load every entry in use
// before evaluating.
module bell_schedule_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [3:0]                  slot,
	input  logic signed [3:0]           weekday,
	input  logic signed [5:0]           hour,
	input  logic signed [6:0]           minute,
	input  logic [4:0]                  day_a,
	input  logic [3:0]                  month_a,
	input  logic [4:0]                  day_b,
	input  logic [3:0]                  month_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ring_now,
	output logic signed [5:0]           next_hour,
	output logic signed [6:0]           next_minute,
	input  logic                        cfg_we,
	input  logic [bsm_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [bsm_pkg::CFG_DW-1:0]  cfg_data
);
	import bsm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	bsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.slot        (slot),
		.weekday     (weekday),
		.hour        (hour),
		.minute      (minute),
		.day_a       (day_a),
		.month_a     (month_a),
		.day_b       (day_b),
		.month_b     (month_b),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stat        (stat),
		.ring_now    (ring_now),
		.next_hour   (next_hour),
		.next_minute (next_minute)
	);

endmodule

/* hw/rtl/bsm_dp.sv */
// Datapath: bell tables, configuration counts, scan evaluation and result register.
module bsm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsm_pkg::cmd_t               cmd,
	input  logic [1:0]                  op,
	input  logic [3:0]                  slot,
	input  logic signed [3:0]           weekday,
	input  logic signed [5:0]           hour,
	input  logic signed [6:0]           minute,
	input  logic [4:0]                  day_a,
	input  logic [3:0]                  month_a,
	input  logic [4:0]                  day_b,
	input  logic [3:0]                  month_b,
	input  logic                        cfg_we,
	input  logic [bsm_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [bsm_pkg::CFG_DW-1:0]  cfg_data,
	output bsm_pkg::stat_t              stat,
	output logic                        ring_now,
	output logic signed [5:0]           next_hour,
	output logic signed [6:0]           next_minute
);
	import bsm_pkg::*;

	logic [4:0] wcount_q;
	logic [3:0] pcount_q;

	logic [16:0] wmem [WEEKLY_SLOTS];
	logic [17:0] pmem [PERIOD_SLOTS];
	logic [12:0] dmem [PERIOD_SLOTS*DAYS];

	logic [16:0] wrd_s1;
	logic [17:0] prd_s1;
	logic [12:0] drd_s1;
	logic        d_ev_s1, w_ev_s1;
	logic [2:0]  off_s1;

	logic signed [3:0]  cwd_q;
	logic signed [5:0]  chr_q;
	logic signed [6:0]  cmn_q;
	logic [10:0]        cdate_q;
	logic signed [11:0] cmin_q;
	logic               wdok_q;

	logic signed [15:0] best_q;
	logic signed [5:0]  nh_q;
	logic signed [6:0]  nm_q;
	logic               ring_q;

	logic               out_ring_q;
	logic signed [5:0]  out_hr_q;
	logic signed [6:0]  out_mn_q;

	logic            in_wd_ok;
	logic            wk_we, pd_we, dl_we;
	logic [DIDX-1:0] dwr_addr, drd_addr;
	logic [3:0]      dsum;
	logic [2:0]      dsel;

	logic [10:0] st_date, en_date;

	logic signed [5:0]  dhr;
	logic signed [6:0]  dmn;
	logic               d_ok, d_take, d_ring;
	logic signed [15:0] d_diff;

	logic signed [3:0]  bwd;
	logic signed [5:0]  bhr;
	logic signed [6:0]  bmn;
	logic               b_every, b_use, b_ok, b_take, b_ring;
	logic [3:0]         dd_raw;
	logic [2:0]         dd;
	logic signed [15:0] b_base, b_add, b_diff;

	// Configuration counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= '0;
			pcount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WEEKLY_COUNT: wcount_q <= cfg_data;
				CFG_PERIOD_COUNT: pcount_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign stat.nw = (32'(wcount_q) > WEEKLY_SLOTS) ? WCW'(WEEKLY_SLOTS) : WCW'(wcount_q);
	assign stat.np = (32'(pcount_q) > PERIOD_SLOTS) ? PCW'(PERIOD_SLOTS) : PCW'(pcount_q);

	// Table writes
	assign in_wd_ok = (weekday >= 4'sd0) && (weekday <= 4'sd6);
	assign wk_we    = cmd.take && (op == OP_LOAD_WEEKLY) && (32'(slot) < WEEKLY_SLOTS);
	assign pd_we    = cmd.take && (op == OP_LOAD_DATES) && (32'(slot) < PERIOD_SLOTS);
	assign dl_we    = cmd.take && (op == OP_LOAD_DAILY) && (32'(slot) < PERIOD_SLOTS)
		&& in_wd_ok;
	assign dwr_addr = DIDX'(32'(slot) * DAYS + 32'(weekday[2:0]));

	// Day of the week being scanned wraps round at the end of the week
	assign dsum     = {1'b0, cwd_q[2:0]} + {1'b0, cmd.off};
	assign dsel     = (dsum >= 4'(DAYS)) ? 3'(dsum - 4'(DAYS)) : dsum[2:0];
	assign drd_addr = DIDX'(32'(cmd.pidx) * DAYS + 32'(dsel));

	always_ff @(posedge clk) begin
		if (wk_we)
			wmem[WIDX'(slot)] <= {weekday, hour, minute};
		if (cmd.w_rd)
			wrd_s1 <= wmem[cmd.widx];
	end

	always_ff @(posedge clk) begin
		if (pd_we)
			pmem[PIDX'(slot)] <= {day_a, month_a, day_b, month_b};
		if (cmd.p_rd)
			prd_s1 <= pmem[cmd.pidx];
	end

	always_ff @(posedge clk) begin
		if (dl_we)
			dmem[dwr_addr] <= {hour, minute};
		if (cmd.d_rd)
			drd_s1 <= dmem[drd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_ev_s1 <= 1'b0;
			w_ev_s1 <= 1'b0;
		end else begin
			d_ev_s1 <= cmd.d_rd;
			w_ev_s1 <= cmd.w_rd;
		end
	end

	always_ff @(posedge clk) begin
		off_s1 <= cmd.off;
	end

	// Capture the current date and time
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cwd_q   <= weekday;
			chr_q   <= hour;
			cmn_q   <= minute;
			cdate_q <= 11'(month_a) * 11'(DATE_SCALE) + 11'(day_a);
			cmin_q  <= 12'(hour) * 12'sd60 + 12'(minute);
			wdok_q  <= in_wd_ok;
		end
	end

	assign stat.wd_ok = wdok_q;

	// Period test, wrapping over new year when start lies after end
	assign st_date = 11'(prd_s1[12:9]) * 11'(DATE_SCALE) + 11'(prd_s1[17:13]);
	assign en_date = 11'(prd_s1[3:0]) * 11'(DATE_SCALE) + 11'(prd_s1[8:4]);
	assign stat.in_per = (st_date <= en_date)
		? ((cdate_q >= st_date) && (cdate_q <= en_date))
		: ((cdate_q >= st_date) || (cdate_q <= en_date));

	// Special daily time
	assign dhr    = drd_s1[12:7];
	assign dmn    = drd_s1[6:0];
	assign d_ok   = !dhr[5] && !dmn[6];
	assign d_diff = 16'(dhr) * 16'sd60 + 16'(dmn) - 16'(cmin_q)
		+ $signed(16'(off_s1) * 16'(DAY_MIN));
	assign d_ring = d_ev_s1 && (off_s1 == 3'd0) && d_ok && (dhr == chr_q) && (dmn == cmn_q);
	assign d_take = d_ev_s1 && d_ok && (d_diff > 16'sd0) && (d_diff < best_q);

	// Weekly bell
	assign bwd     = wrd_s1[16:13];
	assign bhr     = wrd_s1[12:7];
	assign bmn     = wrd_s1[6:0];
	assign b_every = (bwd == -4'sd1);
	assign b_use   = w_ev_s1 && (bwd >= -4'sd1) && (bwd <= 4'sd6) && (b_every || wdok_q);
	assign b_ring  = b_use && (bhr == chr_q) && (bmn == cmn_q) && (b_every || (bwd == cwd_q));
	assign b_ok    = (bhr >= 6'sd0) && (bhr <= 6'sd23) && (bmn >= 7'sd0) && (bmn <= 7'sd59);
	assign b_base  = 16'(bhr) * 16'sd60 + 16'(bmn) - 16'(cmin_q);
	assign dd_raw  = {1'b0, bwd[2:0]} - {1'b0, cwd_q[2:0]};
	assign dd      = dd_raw[3] ? 3'(dd_raw + 4'(DAYS)) : dd_raw[2:0];

	always_comb begin
		if (b_every)
			b_add = (b_base <= 16'sd0) ? 16'(DAY_MIN) : 16'sd0;
		else if (dd == 3'd0)
			b_add = (b_base <= 16'sd0) ? 16'(WEEK_MIN) : 16'sd0;
		else
			b_add = $signed(16'(dd) * 16'(DAY_MIN));
	end

	assign b_diff = b_base + b_add;
	assign b_take = b_use && b_ok && (b_diff > 16'sd0) && (b_diff < best_q);

	// Running best; earlier candidates win ties
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			best_q <= 16'(WEEK_MIN);
			nh_q   <= -6'sd1;
			nm_q   <= -7'sd1;
			ring_q <= 1'b0;
		end else begin
			ring_q <= ring_q | d_ring | b_ring;
			if (d_take) begin
				best_q <= d_diff;
				nh_q   <= dhr;
				nm_q   <= dmn;
			end else if (b_take) begin
				best_q <= b_diff;
				nh_q   <= bhr;
				nm_q   <= bmn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_ring_q <= ring_q;
			out_hr_q   <= nh_q;
			out_mn_q   <= nm_q;
		end
	end

	assign ring_now    = out_ring_q;
	assign next_hour   = out_hr_q;
	assign next_minute = out_mn_q;

	a_one_eval: assert property (@(posedge clk) disable iff (!arst_n)
		!(d_ev_s1 && w_ev_s1))
		else $error("daily and weekly evaluation in the same cycle");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(d_ev_s1 || w_ev_s1))
		else $error("result taken with an evaluation still in flight");

	a_none_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ((next_hour == -6'sd1) == (next_minute == -7'sd1)))
		else $error("next bell hour and minute disagree on none");

endmodule

/* hw/rtl/bsm_ctrl.sv */
// Controller: request sequencing and table scan state machine.
module bsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     op,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  bsm_pkg::stat_t stat,
	output bsm_pkg::cmd_t  cmd
);
	import bsm_pkg::*;

	state_t         state_q, state_d;
	logic [PCW-1:0] pi_q, pi_d;
	logic [2:0]     off_q, off_d;
	logic [WCW-1:0] wi_q, wi_d;
	logic           out_valid_q;
	logic           pi_last, wi_last;

	assign pi_last = ((PCW+1)'(pi_q) + (PCW+1)'(1)) >= (PCW+1)'(stat.np);
	assign wi_last = ((WCW+1)'(wi_q) + (WCW+1)'(1)) >= (WCW+1)'(stat.nw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pi_q    <= '0;
			off_q   <= '0;
			wi_q    <= '0;
		end else begin
			state_q <= state_d;
			pi_q    <= pi_d;
			off_q   <= off_d;
			wi_q    <= wi_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pi_d     = pi_q;
		off_d    = off_q;
		wi_d     = wi_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.pidx = pi_q[PIDX-1:0];
		cmd.off  = off_q;
		cmd.widx = wi_q[WIDX-1:0];
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && (op == OP_EVAL)) begin
					cmd.cap = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				pi_d  = '0;
				wi_d  = '0;
				off_d = '0;
				if (stat.wd_ok && (stat.np != '0))
					state_d = S_P_ADDR;
				else if (stat.nw != '0)
					state_d = S_W_SCAN;
				else
					state_d = S_DRAIN;
			end
			S_P_ADDR: begin
				cmd.p_rd = 1'b1;
				state_d  = S_P_CHK;
			end
			S_P_CHK: begin
				off_d = '0;
				if (stat.in_per)
					state_d = S_D_SCAN;
				else if (!pi_last) begin
					pi_d    = pi_q + 1'b1;
					state_d = S_P_ADDR;
				end else if (stat.nw != '0)
					state_d = S_W_SCAN;
				else
					state_d = S_DRAIN;
			end
			S_D_SCAN: begin
				cmd.d_rd = 1'b1;
				if (off_q != 3'(DAYS - 1))
					off_d = off_q + 1'b1;
				else if (!pi_last) begin
					pi_d    = pi_q + 1'b1;
					state_d = S_P_ADDR;
				end else if (stat.nw != '0)
					state_d = S_W_SCAN;
				else
					state_d = S_DRAIN;
			end
			S_W_SCAN: begin
				cmd.w_rd = 1'b1;
				if (wi_last)
					state_d = S_DRAIN;
				else
					wi_d = wi_q + 1'b1;
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	a_rise_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish step");

	a_period_needs_wd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P_ADDR) |-> stat.wd_ok)
		else $error("period scan with an invalid current weekday");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.w_rd |-> ((WCW+1)'(wi_q) < (WCW+1)'(stat.nw)))
		else $error("weekly scan beyond entries in use");

endmodule
